// ----- design/pulse_gain_sag_tracker_top_assert.svh -----
// Assertion macros used by the pulse gain sag tracker checker
`ifndef PULSE_GAIN_SAG_TRACKER_TOP_ASSERT_SVH
`define PULSE_GAIN_SAG_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define PGST_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define PGST_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/pgst_pkg.sv -----
// Package: shared types, constants, microcode program and exp table builder
`timescale 1ns / 1ps
`default_nettype none

package pgst_pkg;

   // Field widths
   localparam int DropW    = 16;
   localparam int RateW    = 24;
   localparam int DefW     = 16;
   localparam int GainW    = 17;
   localparam int EvtW     = 32;
   localparam int ReqDataW = 32;
   localparam int RspDataW = 24;
   localparam int MulW     = 24;
   localparam int ProdW    = 2 * MulW;
   localparam int TimeMaxW = 48;
   localparam int ShiftW   = 4;
   localparam int PcW      = 4;
   localparam int CsrIdxW  = 1;

   // Command codes (request tuser)
   localparam logic CmdPulse = 1'b0;
   localparam logic CmdQuery = 1'b1;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] RegDrop = 1'b0;
   localparam logic [CsrIdxW-1:0] RegRate = 1'b1;

   // Register reset values
   localparam logic [DropW-1:0] DropReset = 16'd328;
   localparam logic [RateW-1:0] RateReset = 24'd8068;

   // Gain of 1.0 in Q1.16
   localparam logic [GainW-1:0] GainOne = 17'h10000;

   // Exp table construction constants
   localparam logic [63:0] Ln2Q32     = 64'd2977044472;
   localparam int          SeriesTerms = 13;

   // Program step addresses
   localparam logic [PcW-1:0] StepWait  = 4'd0;
   localparam logic [PcW-1:0] StepDt    = 4'd1;
   localparam logic [PcW-1:0] StepMulLo = 4'd2;
   localparam logic [PcW-1:0] StepMulHi = 4'd3;
   localparam logic [PcW-1:0] StepIdx   = 4'd4;
   localparam logic [PcW-1:0] StepRom   = 4'd5;
   localparam logic [PcW-1:0] StepDef   = 4'd6;
   localparam logic [PcW-1:0] StepEmit  = 4'd7;
   localparam logic [PcW-1:0] StepPulse = 4'd8;

   // Datapath operation of one step
   typedef enum logic [3:0] {
      OP_LOAD,
      OP_DT,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_MUL_IDX,
      OP_ROM,
      OP_MUL_DEF,
      OP_EMIT,
      OP_PULSE
   } op_type;

   // Sequencing of one step
   typedef enum logic [1:0] {
      JMP_NEXT,   // always advance
      JMP_REQ,    // advance on an accepted request, else hold
      JMP_OUT,    // hold while output busy; query jumps to target, pulse advances
      JMP_GOTO    // jump to target
   } jmp_type;

   typedef struct packed {
      op_type          op;
      jmp_type         jmp;
      logic [PcW-1:0]  target;
   } ucw_type;

   // Control store
   function automatic ucw_type ucode(input logic [PcW-1:0] pc);
      ucw_type w;
      w = '{op: OP_LOAD, jmp: JMP_GOTO, target: StepWait};
      unique case (pc)
         StepWait:  w = '{op: OP_LOAD,    jmp: JMP_REQ,  target: StepWait};
         StepDt:    w = '{op: OP_DT,      jmp: JMP_NEXT, target: StepWait};
         StepMulLo: w = '{op: OP_MUL_LO,  jmp: JMP_NEXT, target: StepWait};
         StepMulHi: w = '{op: OP_MUL_HI,  jmp: JMP_NEXT, target: StepWait};
         StepIdx:   w = '{op: OP_MUL_IDX, jmp: JMP_NEXT, target: StepWait};
         StepRom:   w = '{op: OP_ROM,     jmp: JMP_NEXT, target: StepWait};
         StepDef:   w = '{op: OP_MUL_DEF, jmp: JMP_NEXT, target: StepWait};
         StepEmit:  w = '{op: OP_EMIT,    jmp: JMP_OUT,  target: StepWait};
         StepPulse: w = '{op: OP_PULSE,   jmp: JMP_GOTO, target: StepWait};
         default:   w = '{op: OP_LOAD,    jmp: JMP_GOTO, target: StepWait};
      endcase
      return w;
   endfunction

   // One table entry: e^-z by a 13-term series in Q0.32, rounded half up to Q1.16.
   // Only evaluated at elaboration for constant z.
   function automatic logic [GainW-1:0] exp_series(input logic [63:0] z);
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] v;
      term = 64'd1 << 32;
      pos  = term;
      neg  = 64'd0;
      for (int i = 1; i < SeriesTerms; i++) begin
         term = ((term * z) >> 32) / 64'(i);
         if (i[0]) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      v = pos - neg;
      return GainW'((v + 64'd32768) >> 16);
   endfunction

endpackage

`default_nettype wire

// ----- design/pgst_exp_rom.sv -----
// Exp table: round(65536 * 2^(-k/N)) built at elaboration, registered read
`timescale 1ns / 1ps
`default_nettype none

module pgst_exp_rom #(
   parameter int ENTRIES = 256
) (
   input  wire logic                              clock,
   input  wire logic                              rd_en,
   input  wire logic [$clog2(ENTRIES)-1:0]        rd_addr,
   output      logic [pgst_pkg::GainW-1:0]        rd_data
);
   import pgst_pkg::*;

   logic [GainW-1:0] rom_tbl [ENTRIES];
   logic [GainW-1:0] rd_data_ff;

   // Constant entries; z = k*ln2/N in Q0.32
   for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
      localparam logic [63:0]      Z   = (64'(k) * Ln2Q32) / ENTRIES;
      localparam logic [GainW-1:0] Val = exp_series(Z);
      assign rom_tbl[k] = Val;
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_tbl[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/pulse_gain_sag_tracker_top.sv -----
// Pulse gain sag tracker: microcoded sequencer with one shared multiplier.
// Each request (tuser = command, tdata = event time) recovers the stored gain
// deficit by 2^-(dt*recovery_rate) and returns the gain 1 - deficit in Q1.16
// (tdata) with an order error flag (tuser); a pulse then folds in one more
// drop, saturating at 65535. Once a request is accepted, a program of one
// step per cycle runs through dt, three products on the shared 24x24
// multiplier, a registered exp table read and the deficit product, then
// loads the output register. A pulse spends one more step on the drop
// update. The next request is taken only once the program is back at its
// wait step, after the output step for a query and after the drop update
// for a pulse. The output step waits while the previous result is still
// held in the output register. Configuration writes land at once and are
// meant for idle periods. No initialization pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module pulse_gain_sag_tracker_top #(
   parameter int TIME_WIDTH        = 32,
   parameter int EXP_TABLE_ENTRIES = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [pgst_pkg::ReqDataW-1:0]       req_tdata,  // [31:0] event_time
   input  wire logic                                req_tuser,  // [0] command
   // result channel
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [pgst_pkg::RspDataW-1:0]       rsp_tdata,  // [16:0] gain, rest zero
   output      logic                                rsp_tuser,  // [0] order_error
   // configuration write port
   input  wire logic                                csr_we,
   input  wire logic [pgst_pkg::CsrIdxW-1:0]        csr_index,
   input  wire logic [pgst_pkg::RateW-1:0]          csr_wdata
);
   import pgst_pkg::*;

   localparam int IdxW = $clog2(EXP_TABLE_ENTRIES);

   // Sequencer
   logic [PcW-1:0]        pc_ff, pc_in;
   ucw_type               ucw;
   logic                  accept;
   logic                  out_free;

   // Configuration and state
   logic [DropW-1:0]      drop_ff, drop_in;
   logic [RateW-1:0]      rate_ff, rate_in;
   logic [DefW-1:0]       deficit_ff, deficit_in;
   logic [TIME_WIDTH-1:0] last_ff, last_in;

   // Working registers
   logic                  cmd_ff, cmd_in;
   logic [TIME_WIDTH-1:0] time_ff, time_in;
   logic                  err_ff, err_in;
   logic [TIME_WIDTH-1:0] dt_ff, dt_in;
   logic [ProdW-1:0]      lo_prod_ff, lo_prod_in;
   logic                  sat_ff, sat_in;
   logic [ShiftW-1:0]     shift_ff, shift_in;
   logic [IdxW-1:0]       idx_ff, idx_in;
   logic [DefW-1:0]       d_ff, d_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [GainW-1:0]      rsp_gain_ff, rsp_gain_in;
   logic                  rsp_err_ff, rsp_err_in;

   // Datapath nets
   logic [TimeMaxW-1:0]   dt_ext;
   logic [MulW-1:0]       mul_a, mul_b;
   logic [ProdW-1:0]      mul_p;
   logic [ProdW:0]        ip_sum;
   logic [GainW-1:0]      rom_q;
   logic [GainW-1:0]      factor;
   logic [DefW:0]         nd_sum;
   logic                  rom_rd;

   assign ucw      = ucode(pc_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (ucw.jmp == JMP_REQ);
   assign accept   = req_tvalid && req_tready;
   assign dt_ext   = TimeMaxW'(dt_ff);
   assign rom_rd   = (ucw.op == OP_ROM);
   assign factor   = sat_ff ? '0 : (rom_q >> shift_ff);

   pgst_exp_rom #(
      .ENTRIES (EXP_TABLE_ENTRIES)
   ) u_exp_rom (
      .clock   (clock),
      .rd_en   (rom_rd),
      .rd_addr (idx_ff),
      .rd_data (rom_q)
   );

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ucw.op)
         OP_MUL_LO: begin
            mul_a = dt_ext[MulW-1:0];
            mul_b = rate_ff;
         end
         OP_MUL_HI: begin
            mul_a = dt_ext[TimeMaxW-1:MulW];
            mul_b = rate_ff;
         end
         OP_MUL_IDX: begin
            mul_a = lo_prod_ff[MulW-1:0];
            mul_b = MulW'(EXP_TABLE_ENTRIES);
         end
         OP_MUL_DEF: begin
            mul_a = MulW'(deficit_ff);
            mul_b = MulW'(factor);
         end
         OP_PULSE: begin
            mul_a = MulW'(d_ff);
            mul_b = MulW'(drop_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = ProdW'(mul_a) * ProdW'(mul_b);
   // integer part of dt*rate: high product plus carry-in from the low product
   assign ip_sum = (ProdW+1)'(mul_p) + (ProdW+1)'(lo_prod_ff[ProdW-1:MulW]);
   // pulse fold-in: d + D - d*D/65536, never negative
   assign nd_sum = (DefW+1)'(d_ff) + (DefW+1)'(drop_ff) - (DefW+1)'(mul_p[31:16]);

   // Step execution and next step
   always_comb begin
      pc_in        = pc_ff;
      drop_in      = drop_ff;
      rate_in      = rate_ff;
      deficit_in   = deficit_ff;
      last_in      = last_ff;
      cmd_in       = cmd_ff;
      time_in      = time_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      lo_prod_in   = lo_prod_ff;
      sat_in       = sat_ff;
      shift_in     = shift_ff;
      idx_in       = idx_ff;
      d_in         = d_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_gain_in  = rsp_gain_ff;
      rsp_err_in   = rsp_err_ff;

      // configuration writes
      if (csr_we) begin
         if (csr_index == RegDrop) begin
            drop_in = csr_wdata[DropW-1:0];
         end
         if (csr_index == RegRate) begin
            rate_in = csr_wdata;
         end
      end

      unique case (ucw.op)
         OP_LOAD: begin
            if (accept) begin
               cmd_in  = req_tuser;
               time_in = TIME_WIDTH'(req_tdata);
            end
         end
         OP_DT: begin
            err_in = (time_ff < last_ff);
            dt_in  = (time_ff < last_ff) ? '0 : (time_ff - last_ff);
         end
         OP_MUL_LO: begin
            lo_prod_in = mul_p;
         end
         OP_MUL_HI: begin
            sat_in   = (ip_sum >= (ProdW+1)'(16));
            shift_in = ip_sum[ShiftW-1:0];
         end
         OP_MUL_IDX: begin
            idx_in = mul_p[MulW +: IdxW];
         end
         OP_ROM: begin
            // table read lands in rom_q
         end
         OP_MUL_DEF: begin
            d_in = (|mul_p[ProdW-1:32]) ? '1 : mul_p[31:16];
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_gain_in  = GainOne - GainW'(d_ff);
               rsp_err_in   = err_ff;
            end
         end
         OP_PULSE: begin
            deficit_in = nd_sum[DefW] ? '1 : nd_sum[DefW-1:0];
            if (!err_ff) begin
               last_in = time_ff;
            end
         end
         default: begin
         end
      endcase

      unique case (ucw.jmp)
         JMP_NEXT: pc_in = pc_ff + 1'b1;
         JMP_REQ:  pc_in = accept ? pc_ff + 1'b1 : pc_ff;
         JMP_OUT: begin
            if (!out_free) begin
               pc_in = pc_ff;
            end else if (cmd_ff == CmdQuery) begin
               pc_in = ucw.target;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         JMP_GOTO: pc_in = ucw.target;
         default:  pc_in = StepWait;
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= StepWait;
         rsp_valid_ff <= 1'b0;
         drop_ff      <= DropReset;
         rate_ff      <= RateReset;
         deficit_ff   <= '0;
         last_ff      <= '0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         drop_ff      <= drop_in;
         rate_ff      <= rate_in;
         deficit_ff   <= deficit_in;
         last_ff      <= last_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      time_ff     <= time_in;
      err_ff      <= err_in;
      dt_ff       <= dt_in;
      lo_prod_ff  <= lo_prod_in;
      sat_ff      <= sat_in;
      shift_ff    <= shift_in;
      idx_ff      <= idx_in;
      d_ff        <= d_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataW'(rsp_gain_ff);
   assign rsp_tuser  = rsp_err_ff;

endmodule

`default_nettype wire

// ----- design/pgst_checker.sv -----
// Port-level checker for the pulse gain sag tracker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "pulse_gain_sag_tracker_top_assert.svh"

module pgst_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [pgst_pkg::RspDataW-1:0] rsp_tdata,
   input wire logic                          rsp_tuser
);
   import pgst_pkg::*;

   logic req_acc;
   logic rsp_stall;

   assign req_acc   = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // a held result keeps its payload
   `PGST_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // the sequencer is busy right after it takes a request
   `PGST_ASSERT_NXT(a_busy_after_req, req_acc, !req_tready, "request taken twice in a row")

   // a result never appears directly after a request
   `PGST_ASSERT_IMP(a_no_fast_rsp, $rose(rsp_tvalid), !$past(req_acc), "result too soon after request")

   // gain stays within 0..1.0 and padding is zero
   `PGST_ASSERT_IMP(a_gain_range, rsp_tvalid, (rsp_tdata[RspDataW-1:GainW] == '0) && (!rsp_tdata[GainW-1] || (rsp_tdata[GainW-2:0] == '0)), "gain out of range")

endmodule

bind pulse_gain_sag_tracker_top pgst_checker u_pgst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ----- verif/pulse_gain_sag_tracker_top_tb.sv -----
// Self-checking testbench for the pulse gain sag tracker: directed rows, then random phases
`timescale 1ns / 1ps

module pulse_gain_sag_tracker_top_tb;
   import pgst_pkg::*;

   localparam int ExpEntries  = 256;
   localparam int ExpIdxW     = $clog2(ExpEntries);
   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 12;
   localparam int SettleCycles = 20;

   // One expected result: gain in Q1.16 and the order error flag
   typedef struct packed {
      logic [GainW-1:0] gain;
      logic             order_err;
   } gain_result_type;

   typedef enum logic {ROW_REQUEST, ROW_CSR_WRITE} row_kind_type;

   // One row of directed stimulus; fixed values override the prediction
   typedef struct {
      row_kind_type         kind;
      logic                 cmd;
      logic [EvtW-1:0]      evt;
      logic [CsrIdxW-1:0]   reg_idx;
      logic [RateW-1:0]     reg_val;
      bit                   fix_gain;
      logic [GainW-1:0]     gain;
      bit                   fix_err;
      logic                 err;
   } stim_row_type;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY4, STALL_RUNS} stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RspDataW-1:0]   rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CsrIdxW-1:0]    csr_index = '0;
   logic [RateW-1:0]      csr_wdata = '0;

   // Predictor state and its copy of the registers
   logic [GainW-1:0]      exp_rom [ExpEntries];
   logic [DefW-1:0]       sag_deficit = '0;
   logic [EvtW-1:0]       sag_last_time = '0;
   logic [DropW-1:0]      cfg_drop = DropReset;
   logic [RateW-1:0]      cfg_rate = RateReset;

   gain_result_type       expected_gain_q [$];
   stim_row_type          directed_rows [$];
   int                    mismatch_count = 0;
   int                    cycle_count = 0;
   int                    burst_left = 0;

   // Receiver stall pattern state
   stall_mode_type        ready_mode = STALL_NONE;
   int                    ready_mode_left = 0;
   int                    ready_phase = 0;
   int                    ready_run_left = 0;
   logic                  ready_level = 1'b0;

   pulse_gain_sag_tracker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] event_time
      .req_tuser  (req_tuser),   // [0] command
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [16:0] gain, rest zero
      .rsp_tuser  (rsp_tuser),   // [0] order_error
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("%0t: run limit reached, %0d results outstanding", $time,
                  expected_gain_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Recover the deficit, report the gain, fold in a pulse
   function automatic gain_result_type track_gain_sag(input logic cmd,
                                                      input logic [EvtW-1:0] evt);
      longint unsigned dt, hi, lo, lo_prod, ip, frac, idx, factor, d, nd;
      gain_result_type res;
      res.order_err = (evt < sag_last_time);
      dt = res.order_err ? 64'd0 : 64'(evt - sag_last_time);
      hi = dt >> 24;
      lo = dt & 64'hFF_FFFF;
      lo_prod = lo * cfg_rate;
      ip = hi * cfg_rate + (lo_prod >> 24);
      frac = lo_prod & 64'hFF_FFFF;
      if (ip >= 16) begin
         factor = 0;
      end else begin
         idx = (frac * ExpEntries) >> 24;
         if (idx >= ExpEntries) idx = ExpEntries - 1;
         factor = 64'(exp_rom[ExpIdxW'(idx)]) >> ip;
      end
      d = (64'(sag_deficit) * factor) >> 16;
      if (d > 65535) d = 65535;
      res.gain = GainW'(64'(GainOne) - d);
      if (cmd == CmdPulse) begin
         nd = d + cfg_drop - ((d * cfg_drop) >> 16);
         if (nd > 65535) nd = 65535;
         sag_deficit = DefW'(nd);
         if (!res.order_err) sag_last_time = evt;
      end
      return res;
   endfunction

   function automatic void add_request(input logic cmd, input logic [EvtW-1:0] evt,
                                       input bit fix_gain, input logic [GainW-1:0] gain,
                                       input bit fix_err, input logic err);
      stim_row_type row;
      row = '{kind: ROW_REQUEST, cmd: cmd, evt: evt, reg_idx: '0, reg_val: '0,
              fix_gain: fix_gain, gain: gain, fix_err: fix_err, err: err};
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void add_csr_write(input logic [CsrIdxW-1:0] idx,
                                         input logic [RateW-1:0] val);
      stim_row_type row;
      row = '{kind: ROW_CSR_WRITE, cmd: CmdQuery, evt: '0, reg_idx: idx, reg_val: val,
              fix_gain: 0, gain: '0, fix_err: 0, err: 1'b0};
      directed_rows = {directed_rows, row};
   endfunction

   // Send one request in bursts with random gaps; predict on acceptance
   task automatic send_request(input logic cmd, input logic [EvtW-1:0] evt,
                               input bit fix_gain, input logic [GainW-1:0] gain,
                               input bit fix_err, input logic err);
      int gap;
      gain_result_type pred;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      end
      burst_left--;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= evt;
      do @(posedge clock); while (req_tready !== 1'b1);
      pred = track_gain_sag(cmd, evt);
      if (fix_gain) pred.gain = gain;
      if (fix_err) pred.order_err = err;
      expected_gain_q = {expected_gain_q, pred};
   endtask

   // Register write once the block has drained
   task automatic write_register(input logic [CsrIdxW-1:0] idx, input logic [RateW-1:0] val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_gain_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == RegDrop) cfg_drop = val[DropW-1:0];
      else cfg_rate = val;
   endtask

   // Mostly time-ordered pulses and queries, some late and some wild requests
   task automatic run_random_phase(input int count);
      logic [EvtW-1:0] base;
      logic [EvtW-1:0] evt;
      logic [EvtW:0]   ahead;
      longint unsigned span;
      longint unsigned dt;
      int              pick;
      logic            cmd;
      for (int n = 0; n < count; n++) begin
         base = sag_last_time;
         // step size scaled so dt*rate spans the interesting exponent range
         span = (cfg_rate == 0) ? (64'd1 << 20) : (64'd24 << 24) / cfg_rate;
         if (span > (64'd1 << 20)) span = 64'd1 << 20;
         pick = $urandom_range(0, 99);
         if (pick < 10) dt = 0;
         else if (pick < 15) dt = 64'($urandom_range(0, 32'd1 << 24));
         else dt = 64'($urandom_range(0, 32'(span)));
         ahead = (EvtW+1)'(base) + (EvtW+1)'(dt);
         evt = ahead[EvtW] ? '1 : ahead[EvtW-1:0];
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            cmd = CmdPulse;
         end else if (pick < 80) begin
            cmd = CmdQuery;
         end else if (pick < 93) begin
            // out-of-order request
            cmd = (pick < 88) ? CmdQuery : CmdPulse;
            evt = (base == 0) ? '0 : base - $urandom_range(1, (base < 5000) ? base : 5000);
         end else begin
            cmd = CmdQuery;
            evt = $urandom;
         end
         send_request(cmd, evt, 0, '0, 0, 1'b0);
      end
   endtask

   // Receiver stalls on its own changing pattern
   always @(negedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode = stall_mode_type'($urandom_range(0, 3));
         ready_mode_left = $urandom_range(32, 256);
      end
      ready_mode_left--;
      ready_phase++;
      case (ready_mode)
         STALL_NONE: begin
            rsp_tready <= 1'b1;
         end
         STALL_COIN: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         STALL_EVERY4: begin
            rsp_tready <= (ready_phase % 4 == 0);
         end
         default: begin
            if (ready_run_left == 0) begin
               ready_level = !ready_level;
               ready_run_left = ready_level ? $urandom_range(1, 4) : $urandom_range(1, 12);
            end
            ready_run_left--;
            rsp_tready <= ready_level;
         end
      endcase
   end

   // Result checker
   always @(posedge clock) begin
      gain_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_gain_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, got gain %0d order_error %0d",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            exp_res = expected_gain_q.pop_front();
            if (rsp_tdata !== RspDataW'(exp_res.gain)) begin
               $display("%0t: gain mismatch: expected %0d, got %0d", $time,
                        exp_res.gain, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== exp_res.order_err) begin
               $display("%0t: order_error mismatch: expected %0d, got %0d", $time,
                        exp_res.order_err, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      longint unsigned z, term, pos, neg;

      // Exp table: 2^-(k/N) by a 13-term series of e^-z in Q0.32, rounded half up
      for (int k = 0; k < ExpEntries; k++) begin
         z = (64'(k) * Ln2Q32) / ExpEntries;
         term = 64'd1 << 32;
         pos = term;
         neg = 0;
         for (int i = 1; i < SeriesTerms; i++) begin
            term = ((term * z) >> 32) / 64'(i);
            if (i % 2 == 1) neg += term;
            else pos += term;
         end
         exp_rom[ExpIdxW'(k)] = GainW'((pos - neg + 64'd32768) >> 16);
      end

      // Directed rows: reset registers first
      add_request(CmdQuery, 32'd0, 1, GainOne, 1, 1'b0);
      add_request(CmdPulse, 32'd0, 1, GainOne, 1, 1'b0);
      add_request(CmdQuery, 32'd0, 1, GainOne - GainW'(DropReset), 1, 1'b0);
      add_request(CmdQuery, 32'hFFFF_FFFF, 1, GainOne, 1, 1'b0);   // full recovery
      add_request(CmdPulse, 32'd1000, 0, '0, 0, 1'b0);
      add_request(CmdQuery, 32'd999, 0, '0, 1, 1'b1);              // late query
      add_request(CmdPulse, 32'd500, 0, '0, 1, 1'b1);              // late pulse still drops
      add_request(CmdQuery, 32'd1000, 0, '0, 1, 1'b0);
      add_request(CmdQuery, 32'd4000, 0, '0, 0, 1'b0);
      add_request(CmdPulse, 32'd20000, 0, '0, 0, 1'b0);
      // full drop, no recovery: deficit saturates
      add_csr_write(RegDrop, 24'h00FFFF);
      add_csr_write(RegRate, 24'd0);
      add_request(CmdPulse, 32'd20000, 0, '0, 0, 1'b0);
      add_request(CmdPulse, 32'd30000, 1, 17'd1, 1, 1'b0);
      add_request(CmdQuery, 32'hFFFF_FFFF, 1, 17'd1, 1, 1'b0);
      // no drop, fastest recovery
      add_csr_write(RegDrop, 24'd0);
      add_csr_write(RegRate, 24'hFF_FFFF);
      add_request(CmdQuery, 32'd30000, 1, 17'd1, 1, 1'b0);
      add_request(CmdQuery, 32'd30001, 0, '0, 0, 1'b0);            // top table entry
      add_request(CmdQuery, 32'd30016, 0, '0, 0, 1'b0);            // largest shift
      add_request(CmdQuery, 32'd30017, 1, GainOne, 1, 1'b0);       // shift past range
      add_request(CmdPulse, 32'd30017, 1, GainOne, 1, 1'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR_WRITE) begin
            write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         end else begin
            send_request(directed_rows[i].cmd, directed_rows[i].evt,
                         directed_rows[i].fix_gain, directed_rows[i].gain,
                         directed_rows[i].fix_err, directed_rows[i].err);
         end
      end

      // Random phases over several register settings
      write_register(RegDrop, 24'(DropReset));
      write_register(RegRate, RateReset);
      run_random_phase(250);
      write_register(RegDrop, 24'($urandom_range(0, 65535)));
      write_register(RegRate, RateW'($urandom & ((32'd1 << $urandom_range(1, 24)) - 1)));
      run_random_phase(250);
      write_register(RegDrop, 24'h00FFFF);
      write_register(RegRate, 24'd1);
      run_random_phase(150);
      write_register(RegDrop, 24'($urandom_range(0, 4000)));
      write_register(RegRate, 24'hFF_FFFF);
      run_random_phase(200);
      write_register(RegDrop, 24'd0);
      write_register(RegRate, RateW'($urandom_range(0, 24'hFF_FFFF)));
      run_random_phase(100);

      // Drain and let the block settle
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_gain_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
